@@ rtl/core/ubds_pkg.sv @@
// ----------------------------------------------------------------------------
// ubds_pkg
// Types, codes and helpers shared by the descriptor scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ubds_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_SHORT       = 2'd1,
    STATUS_NO_IFACE    = 2'd2,
    STATUS_NO_ENDPOINT = 2'd3
  } status_e;

  localparam logic [7:0]  DESC_INTERFACE    = 8'h04;
  localparam logic [7:0]  DESC_ENDPOINT     = 8'h05;
  localparam logic [7:0]  DESC_SS_COMPANION = 8'h30;
  localparam logic [7:0]  MSC_CLASS         = 8'h08;
  localparam logic [7:0]  MSC_SUBCLASS_SCSI = 8'h06;
  localparam logic [7:0]  MSC_PROTOCOL_BOT  = 8'h50;
  localparam logic [1:0]  XFER_BULK         = 2'b10;
  localparam logic [7:0]  MIN_DESC_LENGTH   = 8'd2;
  localparam logic [15:0] CFG_VALUE_POS     = 16'd5;
  localparam logic [15:0] MIN_BUFFER_POS    = 16'd8;
  localparam logic [15:0] POS_MAX           = 16'hFFFF;
  localparam int unsigned BODY_BYTES        = 6;

  typedef struct packed {
    logic [7:0]  cfg;
    logic [7:0]  iface;
    logic [7:0]  in_ep;
    logic [7:0]  out_ep;
    logic [15:0] in_mp;
    logic [15:0] out_mp;
    logic [7:0]  in_burst;
    logic [7:0]  out_burst;
  } capture_t;

  typedef struct packed {
    capture_t cap;
    logic     seen;
    logic     short_buf;
  } walk_view_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  configuration_value;
    logic [7:0]  iface_number;
    logic [7:0]  in_endpoint;
    logic [7:0]  out_endpoint;
    logic [4:0]  in_context_index;
    logic [4:0]  out_context_index;
    logic [15:0] in_max_packet;
    logic [15:0] out_max_packet;
    logic [7:0]  in_max_burst;
    logic [7:0]  out_max_burst;
  } result_t;

  function automatic logic [4:0] ctx_index(input logic [7:0] addr);
    return {addr[3:0], addr[7]};
  endfunction

  function automatic result_t make_result(input walk_view_t v);
    result_t r;
    r = '0;
    if (v.short_buf) begin
      r.status = STATUS_SHORT;
    end else if (!v.seen) begin
      r.status              = STATUS_NO_IFACE;
      r.configuration_value = v.cap.cfg;
    end else begin
      r.configuration_value = v.cap.cfg;
      r.iface_number        = v.cap.iface;
      r.in_endpoint         = v.cap.in_ep;
      r.out_endpoint        = v.cap.out_ep;
      r.in_max_packet       = v.cap.in_mp;
      r.out_max_packet      = v.cap.out_mp;
      r.in_max_burst        = v.cap.in_burst;
      r.out_max_burst       = v.cap.out_burst;
      if (v.cap.in_ep == 8'd0 || v.cap.out_ep == 8'd0) begin
        r.status = STATUS_NO_ENDPOINT;
      end else begin
        r.status            = STATUS_OK;
        r.in_context_index  = ctx_index(v.cap.in_ep);
        r.out_context_index = ctx_index(v.cap.out_ep);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ubds_if.sv @@
// ----------------------------------------------------------------------------
// ubds_if
// Valid/ready channels: descriptor byte stream in, scan result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubds_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface ubds_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  configuration_value;
  logic [7:0]  iface_number;
  logic [7:0]  in_endpoint;
  logic [7:0]  out_endpoint;
  logic [4:0]  in_context_index;
  logic [4:0]  out_context_index;
  logic [15:0] in_max_packet;
  logic [15:0] out_max_packet;
  logic [7:0]  in_max_burst;
  logic [7:0]  out_max_burst;

  modport source (
    output valid, input ready,
    output status, output configuration_value, output iface_number,
    output in_endpoint, output out_endpoint,
    output in_context_index, output out_context_index,
    output in_max_packet, output out_max_packet,
    output in_max_burst, output out_max_burst
  );
  modport sink (
    input valid, output ready,
    input status, input configuration_value, input iface_number,
    input in_endpoint, input out_endpoint,
    input in_context_index, input out_context_index,
    input in_max_packet, input out_max_packet,
    input in_max_burst, input out_max_burst
  );
endinterface

`default_nettype wire

@@ rtl/core/ubds_walker.sv @@
// ----------------------------------------------------------------------------
// ubds_walker
// Descriptor walk state: per-byte offset tracking, descriptor completion and
// capture of the mass-storage interface and its bulk endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

module ubds_walker
  import ubds_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       final_i,
  output walk_view_t      view_o
);

  logic [15:0] pos_q, pos_d;
  logic [7:0]  off_q, off_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  body_q [BODY_BYTES];
  logic [7:0]  body_d [BODY_BYTES];
  logic        stopped_q, stopped_d;
  logic        inside_q, inside_d;
  logic        seen_q, seen_d;
  logic [7:0]  prev_ep_q, prev_ep_d;
  capture_t    cap_q, cap_d;
  logic        desc_done;
  logic        iface_match;

  always_comb begin
    pos_d     = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
    off_d     = off_q;
    len_d     = len_q;
    type_d    = type_q;
    body_d    = body_q;
    stopped_d = stopped_q;
    inside_d  = inside_q;
    seen_d    = seen_q;
    prev_ep_d = prev_ep_q;
    cap_d     = cap_q;
    desc_done = 1'b0;
    iface_match = 1'b0;

    if (pos_q == CFG_VALUE_POS) begin
      cap_d.cfg = byte_i;
    end

    if (!stopped_q) begin
      if (off_q == 8'd0) begin
        for (int i = 0; i < BODY_BYTES; i++) begin
          body_d[i] = 8'd0;
        end
        type_d = 8'd0;
        len_d  = byte_i;
        if (byte_i < MIN_DESC_LENGTH) begin
          stopped_d = 1'b1;
        end
      end else if (off_q == 8'd1) begin
        type_d = byte_i;
      end else begin
        for (int i = 0; i < BODY_BYTES; i++) begin
          if (off_q == 8'(i + 2)) begin
            body_d[i] = byte_i;
          end
        end
      end

      if (!stopped_d) begin
        desc_done = ({1'b0, off_q} + 9'd1) == {1'b0, len_d};
        off_d     = desc_done ? 8'd0 : off_q + 8'd1;
      end
    end

    if (desc_done) begin
      if (type_d == DESC_INTERFACE) begin
        iface_match = body_d[3] == MSC_CLASS && body_d[4] == MSC_SUBCLASS_SCSI &&
                      body_d[5] == MSC_PROTOCOL_BOT && body_d[1] == 8'd0;
        inside_d = iface_match;
        if (iface_match) begin
          seen_d      = 1'b1;
          cap_d.iface = body_d[0];
        end
      end else if (type_d == DESC_ENDPOINT && inside_q) begin
        if (body_d[1][1:0] == XFER_BULK) begin
          if (body_d[0][7]) begin
            cap_d.in_ep = body_d[0];
            cap_d.in_mp = {body_d[3], body_d[2]};
          end else begin
            cap_d.out_ep = body_d[0];
            cap_d.out_mp = {body_d[3], body_d[2]};
          end
          prev_ep_d = body_d[0];
        end
      end else if (type_d == DESC_SS_COMPANION && inside_q && prev_ep_q != 8'd0) begin
        if (prev_ep_q == cap_q.in_ep) begin
          cap_d.in_burst = body_d[0];
        end else if (prev_ep_q == cap_q.out_ep) begin
          cap_d.out_burst = body_d[0];
        end
        prev_ep_d = 8'd0;
      end
    end
  end

  assign view_o.cap       = cap_d;
  assign view_o.seen      = seen_d;
  assign view_o.short_buf = pos_q < MIN_BUFFER_POS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      off_q     <= '0;
      len_q     <= '0;
      type_q    <= '0;
      stopped_q <= 1'b0;
      inside_q  <= 1'b0;
      seen_q    <= 1'b0;
      prev_ep_q <= '0;
      cap_q     <= '0;
      for (int i = 0; i < BODY_BYTES; i++) begin
        body_q[i] <= '0;
      end
    end else if (step_i) begin
      if (final_i) begin
        pos_q     <= '0;
        off_q     <= '0;
        len_q     <= '0;
        type_q    <= '0;
        stopped_q <= 1'b0;
        inside_q  <= 1'b0;
        seen_q    <= 1'b0;
        prev_ep_q <= '0;
        cap_q     <= '0;
        for (int i = 0; i < BODY_BYTES; i++) begin
          body_q[i] <= '0;
        end
      end else begin
        pos_q     <= pos_d;
        off_q     <= off_d;
        len_q     <= len_d;
        type_q    <= type_d;
        stopped_q <= stopped_d;
        inside_q  <= inside_d;
        seen_q    <= seen_d;
        prev_ep_q <= prev_ep_d;
        cap_q     <= cap_d;
        body_q    <= body_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/usb_bot_descriptor_scanner_core.sv @@
// ----------------------------------------------------------------------------
// usb_bot_descriptor_scanner_core
// Scans a USB configuration descriptor set for a Bulk-Only mass-storage
// interface and reports its bulk endpoints.
// ----------------------------------------------------------------------------
// The block takes one descriptor word (byte) per clock cycle with no gaps
// of its own while its result is taken, and returns one result word after
// the word marked final. A word passes an input register and is folded
// into the walk state in the same cycle that the result register loads, so
// a result passes the input register and then the result register. Both
// registers hold when the result is not taken, and the input side keeps
// flowing while the result register is free or being drained. After a
// final word the walk state returns to its reset values for the next buffer.
`default_nettype none

module usb_bot_descriptor_scanner_core
  import ubds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  ubds_byte_if.sink     in_i,
  ubds_result_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       fin_q;
  logic       out_vld_q;
  result_t    res_q;
  logic       advance;
  logic       step;
  walk_view_t view;

  assign advance    = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      fin_q  <= in_i.final_byte;
    end
  end

  ubds_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (byte_q),
    .final_i (fin_q),
    .view_o  (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= step && fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && fin_q) begin
      res_q <= make_result(view);
    end
  end

  assign out_o.valid               = out_vld_q;
  assign out_o.status              = res_q.status;
  assign out_o.configuration_value = res_q.configuration_value;
  assign out_o.iface_number        = res_q.iface_number;
  assign out_o.in_endpoint         = res_q.in_endpoint;
  assign out_o.out_endpoint        = res_q.out_endpoint;
  assign out_o.in_context_index    = res_q.in_context_index;
  assign out_o.out_context_index   = res_q.out_context_index;
  assign out_o.in_max_packet       = res_q.in_max_packet;
  assign out_o.out_max_packet      = res_q.out_max_packet;
  assign out_o.in_max_burst        = res_q.in_max_burst;
  assign out_o.out_max_burst       = res_q.out_max_burst;

  a_result_from_final : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(step && fin_q)
  ) else $error("result raised without a final word");

  a_stalled_input_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(byte_q) && $stable(fin_q)
  ) else $error("input register lost a word under stall");

  a_ok_has_endpoints : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == STATUS_OK |->
      res_q.in_endpoint != 8'd0 && res_q.out_endpoint != 8'd0
  ) else $error("ok status without both endpoints");

  a_short_is_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == STATUS_SHORT |->
      res_q.configuration_value == 8'd0 && res_q.iface_number == 8'd0
  ) else $error("short buffer result carries data");

endmodule

`default_nettype wire
